// ===== rtl/purifier_wash_fill_sequencer_macros.svh =====
// assertion macros for the purifier wash/fill sequencer checker
// included by files that assert; no other dependencies
`ifndef PURIFIER_WASH_FILL_SEQUENCER_MACROS_SVH
`define PURIFIER_WASH_FILL_SEQUENCER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PWFS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pwfs check failed");

// next-cycle implication, disabled while reset is low
`define PWFS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pwfs check failed");

`endif

// ===== rtl/pwfs_pkg.sv =====
// shared types, codes and helpers for the purifier wash/fill sequencer
// no dependencies
`timescale 1ns / 1ps

package pwfs_pkg;

    // config register indexes
    localparam logic [2:0] CFG_WASH_LONG      = 3'd0;
    localparam logic [2:0] CFG_WASH_SHORT     = 3'd1;
    localparam logic [2:0] CFG_RINSE_INTERVAL = 3'd2;
    localparam logic [2:0] CFG_MAX_FILL       = 3'd3;
    localparam logic [2:0] CFG_STARTUP_DELAY  = 3'd4;

    localparam logic [31:0] WASH_LONG_RST      = 32'd18000;
    localparam logic [31:0] WASH_SHORT_RST     = 32'd10000;
    localparam logic [31:0] RINSE_INTERVAL_RST = 32'd3600000;
    localparam logic [31:0] MAX_FILL_RST       = 32'd7200000;
    localparam logic [15:0] STARTUP_DELAY_RST  = 16'd2000;

    // command codes
    localparam logic [1:0] FUNC_CHECK    = 2'd0;
    localparam logic [1:0] FUNC_POWER_ON = 2'd1;
    localparam logic [1:0] FUNC_SHUTDOWN = 2'd2;

    // valve drive codes
    localparam logic [1:0] VALVE_OFF  = 2'd0;
    localparam logic [1:0] VALVE_WASH = 2'd1;
    localparam logic [1:0] VALVE_FILL = 2'd2;

    // beep command codes
    localparam logic [1:0] BEEP_NONE       = 2'd0;
    localparam logic [1:0] BEEP_ONE_RAPID  = 2'd1;
    localparam logic [1:0] BEEP_TEN_NORMAL = 2'd2;
    localparam logic [1:0] BEEP_LONG_RAPID = 2'd3;

    // reported run state codes
    localparam logic [1:0] RUN_CODE_POWERED = 2'd0;
    localparam logic [1:0] RUN_CODE_ON      = 2'd1;
    localparam logic [1:0] RUN_CODE_RUNNING = 2'd2;
    localparam logic [1:0] RUN_CODE_DOWN    = 2'd3;

    // reported task codes
    localparam logic [2:0] TASK_CODE_IDLE = 3'd0;
    localparam logic [2:0] TASK_CODE_WASH = 3'd1;
    localparam logic [2:0] TASK_CODE_FILL = 3'd2;
    localparam logic [2:0] TASK_CODE_LACK = 3'd3;
    localparam logic [2:0] TASK_CODE_FULL = 3'd4;

    // alarm bit positions
    localparam int ALM_WASH  = 0;
    localparam int ALM_FILL  = 1;
    localparam int ALM_LACK  = 2;
    localparam int ALM_FULL  = 3;
    localparam int ALM_FAULT = 4;

    localparam int IN_BYTES  = 5;
    localparam int OUT_BYTES = 2;

    typedef enum logic [3:0] {
        RUN_POWERED = 4'b0001,
        RUN_ON      = 4'b0010,
        RUN_RUNNING = 4'b0100,
        RUN_DOWN    = 4'b1000
    } run_t;

    typedef enum logic [4:0] {
        TASK_IDLE = 5'b00001,
        TASK_WASH = 5'b00010,
        TASK_FILL = 5'b00100,
        TASK_LACK = 5'b01000,
        TASK_FULL = 5'b10000
    } task_t;

    typedef struct packed {
        logic [31:0] wash_long_ms;
        logic [31:0] wash_short_ms;
        logic [31:0] rinse_interval_ms;
        logic [31:0] max_fill_ms;
        logic [15:0] startup_delay_ms;
    } cfg_t;

    typedef struct packed {
        logic        wash_key_long;
        logic        high_switch_high;
        logic        low_switch_high;
        logic [31:0] now_ms;
        logic [1:0]  func;
    } item_t;

    typedef struct packed {
        run_t        run_mode;
        task_t       task_cur;
        logic        wash_begun;
        logic        fill_begun;
        logic        use_short_wash;
        logic [31:0] wash_start_time;
        logic [31:0] fill_start_time;
        logic [4:0]  alarm_active;
    } state_t;

    typedef struct packed {
        logic [2:0] task_now;
        logic [1:0] run_state;
        logic       beep_stop;
        logic [1:0] beep_start;
        logic [1:0] valve_drive;
    } result_t;

    function automatic logic [1:0] run_code(run_t r);
        logic [1:0] c;
        case (r)
            RUN_POWERED: c = RUN_CODE_POWERED;
            RUN_ON:      c = RUN_CODE_ON;
            RUN_RUNNING: c = RUN_CODE_RUNNING;
            RUN_DOWN:    c = RUN_CODE_DOWN;
            default:     c = RUN_CODE_POWERED;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] task_code(task_t t);
        logic [2:0] c;
        case (t)
            TASK_IDLE: c = TASK_CODE_IDLE;
            TASK_WASH: c = TASK_CODE_WASH;
            TASK_FILL: c = TASK_CODE_FILL;
            TASK_LACK: c = TASK_CODE_LACK;
            TASK_FULL: c = TASK_CODE_FULL;
            default:   c = TASK_CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/pwfs_cfg_regs.sv =====
// configuration register file for the wash/fill sequencer
// depends on pwfs_pkg
`timescale 1ns / 1ps

module pwfs_cfg_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [2:0]        wr_index,
    input  logic [31:0]       wr_data,
    output pwfs_pkg::cfg_t    cfg
);

    pwfs_pkg::cfg_t cfg_reg;
    pwfs_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                pwfs_pkg::CFG_WASH_LONG:      cfg_next.wash_long_ms      = wr_data;
                pwfs_pkg::CFG_WASH_SHORT:     cfg_next.wash_short_ms     = wr_data;
                pwfs_pkg::CFG_RINSE_INTERVAL: cfg_next.rinse_interval_ms = wr_data;
                pwfs_pkg::CFG_MAX_FILL:       cfg_next.max_fill_ms       = wr_data;
                pwfs_pkg::CFG_STARTUP_DELAY:  cfg_next.startup_delay_ms  = wr_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wash_long_ms      <= pwfs_pkg::WASH_LONG_RST;
            cfg_reg.wash_short_ms     <= pwfs_pkg::WASH_SHORT_RST;
            cfg_reg.rinse_interval_ms <= pwfs_pkg::RINSE_INTERVAL_RST;
            cfg_reg.max_fill_ms       <= pwfs_pkg::MAX_FILL_RST;
            cfg_reg.startup_delay_ms  <= pwfs_pkg::STARTUP_DELAY_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/pwfs_step.sv =====
// next-state and result logic for one item of the wash/fill sequencer
// depends on pwfs_pkg
`timescale 1ns / 1ps

module pwfs_step (
    input  pwfs_pkg::cfg_t    cfg,
    input  pwfs_pkg::item_t   item,
    input  pwfs_pkg::state_t  state_cur,
    output pwfs_pkg::state_t  state_upd,
    output pwfs_pkg::result_t result
);

    always_comb begin
        pwfs_pkg::state_t st;
        logic [1:0]  bp_code;
        logic        bp_cancel;
        logic [31:0] wash_len;
        logic [31:0] wash_end;
        logic [31:0] rinse_at;
        logic [31:0] fill_end;
        logic        lack;
        logic        full;
        logic        key;
        logic [31:0] now;

        st        = state_cur;
        bp_code   = pwfs_pkg::BEEP_NONE;
        bp_cancel = 1'b0;
        wash_len  = '0;
        wash_end  = '0;
        rinse_at  = '0;
        fill_end  = '0;
        lack      = item.low_switch_high;
        full      = item.high_switch_high;
        key       = item.wash_key_long;
        now       = item.now_ms;

        case (item.func)
            pwfs_pkg::FUNC_POWER_ON: begin
                st.run_mode = pwfs_pkg::RUN_ON;
            end
            pwfs_pkg::FUNC_SHUTDOWN: begin
                st.run_mode = pwfs_pkg::RUN_DOWN;
                case (st.task_cur)
                    pwfs_pkg::TASK_FILL: begin
                        st.fill_begun = 1'b0;
                        st.alarm_active[pwfs_pkg::ALM_FILL] = 1'b0;
                        bp_cancel = 1'b1;
                        bp_code   = pwfs_pkg::BEEP_NONE;
                    end
                    pwfs_pkg::TASK_WASH: begin
                        st.wash_begun = 1'b0;
                        st.alarm_active[pwfs_pkg::ALM_WASH] = 1'b0;
                    end
                    pwfs_pkg::TASK_FULL: begin
                        st.alarm_active[pwfs_pkg::ALM_FULL] = 1'b0;
                        bp_cancel = 1'b1;
                        bp_code   = pwfs_pkg::BEEP_NONE;
                    end
                    pwfs_pkg::TASK_LACK: begin
                        st.alarm_active[pwfs_pkg::ALM_LACK] = 1'b0;
                        bp_cancel = 1'b1;
                        bp_code   = pwfs_pkg::BEEP_NONE;
                    end
                    default: ;
                endcase
                st.task_cur = pwfs_pkg::TASK_IDLE;
            end
            pwfs_pkg::FUNC_CHECK: begin
                case (st.run_mode)
                    pwfs_pkg::RUN_ON: begin
                        if (now >= {16'd0, cfg.startup_delay_ms}) begin
                            st.run_mode = pwfs_pkg::RUN_RUNNING;
                        end
                    end
                    pwfs_pkg::RUN_DOWN: begin
                        // fault alarm fires only once after reset
                        if (!st.alarm_active[pwfs_pkg::ALM_FAULT]) begin
                            bp_cancel = 1'b1;
                            bp_code   = pwfs_pkg::BEEP_LONG_RAPID;
                            st.alarm_active[pwfs_pkg::ALM_FAULT] = 1'b1;
                        end
                    end
                    pwfs_pkg::RUN_RUNNING: begin
                        // lack pulls wash, fill and full into lack; a long key press below still wins
                        if (lack) begin
                            case (st.task_cur)
                                pwfs_pkg::TASK_FILL: begin
                                    st.fill_begun = 1'b0;
                                    st.alarm_active[pwfs_pkg::ALM_FILL] = 1'b0;
                                    bp_cancel   = 1'b1;
                                    bp_code     = pwfs_pkg::BEEP_NONE;
                                    st.task_cur = pwfs_pkg::TASK_LACK;
                                end
                                pwfs_pkg::TASK_WASH: begin
                                    st.wash_begun = 1'b0;
                                    st.alarm_active[pwfs_pkg::ALM_WASH] = 1'b0;
                                    st.task_cur = pwfs_pkg::TASK_LACK;
                                end
                                pwfs_pkg::TASK_FULL: begin
                                    st.alarm_active[pwfs_pkg::ALM_FULL] = 1'b0;
                                    bp_cancel   = 1'b1;
                                    bp_code     = pwfs_pkg::BEEP_NONE;
                                    st.task_cur = pwfs_pkg::TASK_LACK;
                                end
                                default: ;
                            endcase
                        end
                        // long key press forces a long wash
                        if (key) begin
                            if (st.task_cur == pwfs_pkg::TASK_FILL) begin
                                st.alarm_active[pwfs_pkg::ALM_FILL] = 1'b0;
                                bp_cancel = 1'b1;
                                bp_code   = pwfs_pkg::BEEP_NONE;
                            end else if (st.task_cur == pwfs_pkg::TASK_FULL) begin
                                st.alarm_active[pwfs_pkg::ALM_FULL] = 1'b0;
                                bp_cancel = 1'b1;
                                bp_code   = pwfs_pkg::BEEP_NONE;
                            end
                            st.use_short_wash = 1'b0;
                            st.task_cur       = pwfs_pkg::TASK_WASH;
                        end

                        wash_len = st.use_short_wash ? cfg.wash_short_ms : cfg.wash_long_ms;
                        wash_end = st.wash_start_time + wash_len;
                        rinse_at = st.wash_start_time + cfg.rinse_interval_ms;
                        fill_end = st.fill_start_time + cfg.max_fill_ms;

                        case (st.task_cur)
                            pwfs_pkg::TASK_IDLE: begin
                                st.task_cur = lack ? pwfs_pkg::TASK_LACK : pwfs_pkg::TASK_WASH;
                            end
                            pwfs_pkg::TASK_WASH: begin
                                if (!st.wash_begun) begin
                                    st.wash_begun      = 1'b1;
                                    st.wash_start_time = now;
                                end else begin
                                    st.alarm_active[pwfs_pkg::ALM_WASH] = 1'b1;
                                    if (now >= wash_end) begin
                                        st.wash_begun      = 1'b0;
                                        st.wash_start_time = now;
                                        st.alarm_active[pwfs_pkg::ALM_WASH] = 1'b0;
                                        st.task_cur = full ? pwfs_pkg::TASK_FULL
                                                           : pwfs_pkg::TASK_FILL;
                                    end
                                end
                            end
                            pwfs_pkg::TASK_FILL: begin
                                if (full) begin
                                    st.alarm_active[pwfs_pkg::ALM_FILL] = 1'b0;
                                    bp_cancel          = 1'b1;
                                    bp_code            = pwfs_pkg::BEEP_NONE;
                                    st.fill_begun      = 1'b0;
                                    st.fill_start_time = '0;
                                    st.task_cur        = pwfs_pkg::TASK_FULL;
                                end else if (!st.fill_begun) begin
                                    st.fill_begun      = 1'b1;
                                    st.fill_start_time = now;
                                end else begin
                                    if (!st.alarm_active[pwfs_pkg::ALM_FILL]) begin
                                        bp_cancel = 1'b1;
                                        bp_code   = pwfs_pkg::BEEP_ONE_RAPID;
                                        st.alarm_active[pwfs_pkg::ALM_FILL] = 1'b1;
                                    end
                                    // periodic rinse
                                    if (now >= rinse_at) begin
                                        st.alarm_active[pwfs_pkg::ALM_FILL] = 1'b0;
                                        bp_cancel         = 1'b1;
                                        bp_code           = pwfs_pkg::BEEP_NONE;
                                        st.use_short_wash = 1'b1;
                                        st.task_cur       = pwfs_pkg::TASK_WASH;
                                    end
                                    // overlong fill is a fault
                                    if (now >= fill_end) begin
                                        st.run_mode = pwfs_pkg::RUN_DOWN;
                                        st.task_cur = pwfs_pkg::TASK_IDLE;
                                        st.alarm_active[pwfs_pkg::ALM_FILL] = 1'b0;
                                        bp_cancel          = 1'b1;
                                        bp_code            = pwfs_pkg::BEEP_NONE;
                                        st.fill_begun      = 1'b0;
                                        st.fill_start_time = '0;
                                    end
                                end
                            end
                            pwfs_pkg::TASK_LACK: begin
                                if (!lack) begin
                                    st.alarm_active[pwfs_pkg::ALM_LACK] = 1'b0;
                                    bp_cancel         = 1'b1;
                                    bp_code           = pwfs_pkg::BEEP_NONE;
                                    st.use_short_wash = 1'b0;
                                    st.task_cur       = pwfs_pkg::TASK_WASH;
                                end else if (!st.alarm_active[pwfs_pkg::ALM_LACK]) begin
                                    bp_cancel = 1'b1;
                                    bp_code   = pwfs_pkg::BEEP_TEN_NORMAL;
                                    st.alarm_active[pwfs_pkg::ALM_LACK] = 1'b1;
                                end
                            end
                            pwfs_pkg::TASK_FULL: begin
                                if (!full) begin
                                    st.alarm_active[pwfs_pkg::ALM_FULL] = 1'b0;
                                    bp_cancel   = 1'b1;
                                    bp_code     = pwfs_pkg::BEEP_NONE;
                                    st.task_cur = pwfs_pkg::TASK_FILL;
                                end else if (!st.alarm_active[pwfs_pkg::ALM_FULL]) begin
                                    bp_cancel = 1'b1;
                                    bp_code   = pwfs_pkg::BEEP_ONE_RAPID;
                                    st.alarm_active[pwfs_pkg::ALM_FULL] = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        state_upd = st;

        if (st.alarm_active[pwfs_pkg::ALM_FILL]) begin
            result.valve_drive = pwfs_pkg::VALVE_FILL;
        end else if (st.alarm_active[pwfs_pkg::ALM_WASH]) begin
            result.valve_drive = pwfs_pkg::VALVE_WASH;
        end else begin
            result.valve_drive = pwfs_pkg::VALVE_OFF;
        end
        result.beep_start = bp_code;
        result.beep_stop  = bp_cancel;
        result.run_state  = pwfs_pkg::run_code(st.run_mode);
        result.task_now   = pwfs_pkg::task_code(st.task_cur);
    end

endmodule

// ===== rtl/purifier_wash_fill_sequencer.sv =====
// top level of the purifier wash/fill sequencer: input stage, state, result register
// depends on pwfs_pkg, pwfs_cfg_regs and pwfs_step
`timescale 1ns / 1ps

// Water purifier wash/fill sequencer. Each input transfer is one command (check,
// power on, shut down) with the millisecond time, the low and high pressure switch
// levels and the wash key long press; each one yields exactly one result transfer
// with the valve drive, a one-shot beep start/stop command, the run state and the
// task. A transfer is held in an input register and processed, once the result
// register is free or being emptied, by a single pass of compare-and-transition
// logic that updates the sequencer state and loads the result register, so one
// item is taken every cycle while the output side is not stalled. A result is
// held in the result register until the output side is ready. The input register
// keeps accepting while a result waits to be taken, until both stages are full.
// The rate of one item per cycle is set by the state update loop. The config port
// is always ready; write it only while no item is in flight. Time compares are
// plain unsigned compares with 32-bit wrapping sums.
module purifier_wash_fill_sequencer (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,

    // command stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    // func[1:0], now_ms[33:2], low_switch_high[34], high_switch_high[35],
    // wash_key_long[36], zero fill [39:37]
    input  logic [8*pwfs_pkg::IN_BYTES-1:0]  s_tdata,

    // result stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    // valve_drive[1:0], beep_start[3:2], beep_stop[4], run_state[6:5],
    // task_now[9:7], zero fill [15:10]
    output logic [8*pwfs_pkg::OUT_BYTES-1:0] m_tdata
);

    localparam int ItemW = $bits(pwfs_pkg::item_t);
    localparam int ResW  = $bits(pwfs_pkg::result_t);

    pwfs_pkg::cfg_t    cfg;
    pwfs_pkg::state_t  state_reg;
    pwfs_pkg::state_t  state_next;
    pwfs_pkg::state_t  state_upd;
    pwfs_pkg::item_t   item_reg;
    pwfs_pkg::item_t   item_next;
    pwfs_pkg::result_t res_reg;
    pwfs_pkg::result_t res_next;
    pwfs_pkg::result_t res_comb;
    logic              in_vld_reg;
    logic              in_vld_next;
    logic              out_vld_reg;
    logic              out_vld_next;
    logic              advance;
    logic              s_xfer;

    // register writes are always accepted; nothing to wait for
    assign cfg_ready = 1'b1;

    pwfs_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    pwfs_step u_step (
        .cfg       (cfg),
        .item      (item_reg),
        .state_cur (state_reg),
        .state_upd (state_upd),
        .result    (res_comb)
    );

    // the held item moves on when the result register is free or being emptied
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb begin
        item_next    = s_xfer ? pwfs_pkg::item_t'(s_tdata[ItemW-1:0]) : item_reg;
        in_vld_next  = s_xfer ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
        state_next   = advance ? state_upd : state_reg;
        res_next     = advance ? res_comb : res_reg;
        out_vld_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_vld_reg);
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        res_reg  <= res_next;
    end

    // control and sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg                <= 1'b0;
            out_vld_reg               <= 1'b0;
            state_reg.run_mode        <= pwfs_pkg::RUN_POWERED;
            state_reg.task_cur        <= pwfs_pkg::TASK_IDLE;
            state_reg.wash_begun      <= 1'b0;
            state_reg.fill_begun      <= 1'b0;
            state_reg.use_short_wash  <= 1'b0;
            state_reg.wash_start_time <= '0;
            state_reg.fill_start_time <= '0;
            state_reg.alarm_active    <= '0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            state_reg   <= state_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(8*pwfs_pkg::OUT_BYTES-ResW){1'b0}}, res_reg};

endmodule

// ===== rtl/pwfs_checker.sv =====
// port-level checks for the purifier wash/fill sequencer, bound to the top level
// depends on purifier_wash_fill_sequencer_macros.svh and pwfs_pkg
`timescale 1ns / 1ps

`include "purifier_wash_fill_sequencer_macros.svh"

module pwfs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a stalled result holds
    `PWFS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // no valve code beyond fill pump
    `PWFS_ASSERT_NOW(a_valve_range, aclk, aresetn, m_tvalid, m_tdata[1:0] != 2'd3)

    // every beep start is preceded by a cancel in the same item
    `PWFS_ASSERT_NOW(a_beep_cancel, aclk, aresetn, m_tvalid && (m_tdata[3:2] != pwfs_pkg::BEEP_NONE), m_tdata[4])

    // fill pump runs only while the fill task is current
    `PWFS_ASSERT_NOW(a_pump_fill, aclk, aresetn, m_tvalid && (m_tdata[1:0] == pwfs_pkg::VALVE_FILL), m_tdata[9:7] == pwfs_pkg::TASK_CODE_FILL)

endmodule

bind purifier_wash_fill_sequencer pwfs_checker u_pwfs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/tb_purifier_wash_fill_sequencer.sv =====
`timescale 1ns / 1ps
// self-checking testbench for purifier_wash_fill_sequencer: directed command scenarios,
// then randomized power/check sessions under several timer settings, scored by a local model
// depends on pwfs_pkg and the sequencer rtl

module tb_purifier_wash_fill_sequencer;
    import pwfs_pkg::*;

    // command and register codes that the package leaves unnamed
    localparam logic [1:0] FUNC_UNUSED  = 2'd3;
    localparam logic [2:0] CFG_UNMAPPED = 3'd7;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [2:0]             cfg_index = '0;
    logic [31:0]            cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [8*IN_BYTES-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [8*OUT_BYTES-1:0] m_tdata;

    purifier_wash_fill_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // sequencer model: timer settings, run/task state, per-command beep
    // ------------------------------------------------------------------
    logic [31:0] wash_long_len, wash_short_len, rinse_every, fill_limit;
    logic [15:0] startup_at;

    logic [1:0]  seq_run;
    logic [2:0]  seq_task;
    bit          wash_timing, fill_timing, short_wash;
    logic [31:0] wash_t0, fill_t0;
    logic [4:0]  alarms;

    logic [1:0]  beep_cmd;
    bit          beep_cancel;

    result_t     expected_outputs[$];

    int errors, commands_sent, results_taken;
    int task_hits[5];
    int beep_hits[4];

    bit gaps_on   = 1'b1;
    bit stalls_on = 1'b1;
    int tready_hold = 0;

    function automatic void init_model();
        wash_long_len  = 32'd18000;
        wash_short_len = 32'd10000;
        rinse_every    = 32'd3600000;
        fill_limit     = 32'd7200000;
        startup_at     = 16'd2000;
        seq_run        = RUN_CODE_POWERED;
        seq_task       = TASK_CODE_IDLE;
        wash_timing    = 1'b0;
        fill_timing    = 1'b0;
        short_wash     = 1'b0;
        wash_t0        = '0;
        fill_t0        = '0;
        alarms         = '0;
    endfunction

    // a start always issues a cancel first, so both flags rise together
    function automatic void cancel_beep();
        beep_cancel = 1'b1;
        beep_cmd    = BEEP_NONE;
    endfunction

    function automatic void start_beep(input logic [1:0] code);
        cancel_beep();
        beep_cmd = code;
    endfunction

    function automatic void exit_fill();
        alarms[ALM_FILL] = 1'b0;
        cancel_beep();
    endfunction

    function automatic void exit_lack();
        alarms[ALM_LACK] = 1'b0;
        cancel_beep();
    endfunction

    function automatic void exit_full();
        alarms[ALM_FULL] = 1'b0;
        cancel_beep();
    endfunction

    function automatic void exit_wash();
        alarms[ALM_WASH] = 1'b0;
    endfunction

    function automatic void run_tasks(input logic [31:0] now_ms, input bit lack,
                                      input bit full, input bit key);
        logic [31:0] deadline;
        // low pressure pulls any active task into lack
        if (lack) begin
            case (seq_task)
                TASK_CODE_FILL: begin
                    fill_timing = 1'b0;
                    exit_fill();
                    seq_task = TASK_CODE_LACK;
                end
                TASK_CODE_WASH: begin
                    wash_timing = 1'b0;
                    exit_wash();
                    seq_task = TASK_CODE_LACK;
                end
                TASK_CODE_FULL: begin
                    exit_full();
                    seq_task = TASK_CODE_LACK;
                end
                default: ;
            endcase
        end
        // long key press forces a long wash from any task
        if (key) begin
            if (seq_task == TASK_CODE_FILL) exit_fill();
            else if (seq_task == TASK_CODE_FULL) exit_full();
            short_wash = 1'b0;
            seq_task   = TASK_CODE_WASH;
        end
        case (seq_task)
            TASK_CODE_IDLE: seq_task = lack ? TASK_CODE_LACK : TASK_CODE_WASH;
            TASK_CODE_WASH: begin
                if (!wash_timing) begin
                    wash_timing = 1'b1;
                    wash_t0     = now_ms;
                end else begin
                    deadline = wash_t0 + (short_wash ? wash_short_len : wash_long_len);
                    alarms[ALM_WASH] = 1'b1;
                    if (now_ms >= deadline) begin
                        wash_timing = 1'b0;
                        wash_t0     = now_ms;
                        exit_wash();
                        seq_task = full ? TASK_CODE_FULL : TASK_CODE_FILL;
                    end
                end
            end
            TASK_CODE_FILL: begin
                if (full) begin
                    exit_fill();
                    fill_timing = 1'b0;
                    fill_t0     = '0;
                    seq_task    = TASK_CODE_FULL;
                end else if (!fill_timing) begin
                    fill_timing = 1'b1;
                    fill_t0     = now_ms;
                end else begin
                    if (!alarms[ALM_FILL]) begin
                        start_beep(BEEP_ONE_RAPID);
                        alarms[ALM_FILL] = 1'b1;
                    end
                    // periodic rinse keeps the fill timer running
                    deadline = wash_t0 + rinse_every;
                    if (now_ms >= deadline) begin
                        exit_fill();
                        short_wash = 1'b1;
                        seq_task   = TASK_CODE_WASH;
                    end
                    deadline = fill_t0 + fill_limit;
                    if (now_ms >= deadline) begin
                        seq_run  = RUN_CODE_DOWN;
                        seq_task = TASK_CODE_IDLE;
                        exit_fill();
                        fill_timing = 1'b0;
                        fill_t0     = '0;
                    end
                end
            end
            TASK_CODE_LACK: begin
                if (!lack) begin
                    exit_lack();
                    short_wash = 1'b0;
                    seq_task   = TASK_CODE_WASH;
                end else if (!alarms[ALM_LACK]) begin
                    start_beep(BEEP_TEN_NORMAL);
                    alarms[ALM_LACK] = 1'b1;
                end
            end
            TASK_CODE_FULL: begin
                if (!full) begin
                    exit_full();
                    seq_task = TASK_CODE_FILL;
                end else if (!alarms[ALM_FULL]) begin
                    start_beep(BEEP_ONE_RAPID);
                    alarms[ALM_FULL] = 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void power_down();
        seq_run = RUN_CODE_DOWN;
        case (seq_task)
            TASK_CODE_FILL: begin
                fill_timing = 1'b0;
                exit_fill();
            end
            TASK_CODE_WASH: begin
                wash_timing = 1'b0;
                exit_wash();
            end
            TASK_CODE_FULL: exit_full();
            TASK_CODE_LACK: exit_lack();
            default: ;
        endcase
        seq_task = TASK_CODE_IDLE;
    endfunction

    // advances the model by one command and returns the outputs it should report
    function automatic result_t sequencer_step(input item_t cmd);
        result_t r;
        beep_cmd    = BEEP_NONE;
        beep_cancel = 1'b0;
        case (cmd.func)
            FUNC_POWER_ON: seq_run = RUN_CODE_ON;
            FUNC_SHUTDOWN: power_down();
            FUNC_CHECK: begin
                if (seq_run == RUN_CODE_ON) begin
                    if (cmd.now_ms >= {16'd0, startup_at}) seq_run = RUN_CODE_RUNNING;
                end else if (seq_run == RUN_CODE_DOWN) begin
                    // fault alarm sounds only once after reset
                    if (!alarms[ALM_FAULT]) begin
                        start_beep(BEEP_LONG_RAPID);
                        alarms[ALM_FAULT] = 1'b1;
                    end
                end else if (seq_run == RUN_CODE_RUNNING) begin
                    run_tasks(cmd.now_ms, cmd.low_switch_high, cmd.high_switch_high,
                              cmd.wash_key_long);
                end
            end
            default: ;
        endcase
        if (alarms[ALM_FILL]) r.valve_drive = VALVE_FILL;
        else if (alarms[ALM_WASH]) r.valve_drive = VALVE_WASH;
        else r.valve_drive = VALVE_OFF;
        r.beep_start = beep_cmd;
        r.beep_stop  = beep_cancel;
        r.run_state  = seq_run;
        r.task_now   = seq_task;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one command transfer; the expectation is recorded at the accepting edge
    task automatic send_cmd(input logic [1:0] func, input logic [31:0] now_ms,
                            input bit lack, input bit full, input bit key);
        item_t   cmd;
        result_t want;
        int      gap;
        cmd.func             = func;
        cmd.now_ms           = now_ms;
        cmd.low_switch_high  = lack;
        cmd.high_switch_high = full;
        cmd.wash_key_long    = key;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, cmd};
        do @(posedge aclk); while (!s_tready);
        want = sequencer_step(cmd);
        expected_outputs.push_back(want);
        commands_sent++;
        task_hits[want.task_now]++;
        beep_hits[want.beep_start]++;
    endtask

    // hold the command stream until every result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_outputs.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_WASH_LONG:      wash_long_len  = val;
            CFG_WASH_SHORT:     wash_short_len = val;
            CFG_RINSE_INTERVAL: rinse_every    = val;
            CFG_MAX_FILL:       fill_limit     = val;
            CFG_STARTUP_DELAY:  startup_at     = val[15:0];
            default: ;
        endcase
    endtask

    // reprogram all timers while nothing is in flight; upper data bits of the
    // 16-bit startup register carry junk that must be dropped
    task automatic load_timers(input logic [31:0] wl, input logic [31:0] ws,
                               input logic [31:0] ri, input logic [31:0] mf,
                               input logic [15:0] sd, input bit poke_unmapped);
        logic [15:0] junk;
        junk = 16'($urandom_range(0, 16'hFFFF));
        drain_results();
        write_reg(CFG_WASH_LONG, wl);
        write_reg(CFG_WASH_SHORT, ws);
        write_reg(CFG_RINSE_INTERVAL, ri);
        write_reg(CFG_MAX_FILL, mf);
        write_reg(CFG_STARTUP_DELAY, {junk, sd});
        if (poke_unmapped) write_reg(CFG_UNMAPPED, $urandom());
        cfg_valid <= 1'b0;
    endtask

    // result side: random stalls, mostly short, now and then long
    always @(posedge aclk) begin
        if (tready_hold > 0) begin
            tready_hold <= tready_hold - 1;
            m_tready    <= 1'b0;
        end else if (stalls_on && $urandom_range(0, 99) < 20) begin
            tready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                        : $urandom_range(0, 2);
            m_tready    <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // result checking, oldest expectation first
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [2:0] want,
                                        input logic [2:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin : take_result
        result_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[$bits(result_t)-1:0]);
            results_taken++;
            if (expected_outputs.size() == 0) begin
                errors++;
                $display("%0t: result transfer with nothing expected, expected none actual %h",
                         $time, m_tdata);
            end else begin
                want = expected_outputs.pop_front();
                check_field("valve_drive", 3'(want.valve_drive), 3'(got.valve_drive));
                check_field("beep_start", 3'(want.beep_start), 3'(got.beep_start));
                check_field("beep_stop", 3'(want.beep_stop), 3'(got.beep_stop));
                check_field("run_state", 3'(want.run_state), 3'(got.run_state));
                check_field("task_now", want.task_now, got.task_now);
            end
        end
    end

    // ------------------------------------------------------------------
    // random sessions: power on near the startup threshold, then a mostly
    // monotonic clock with slowly changing switches, some noise mixed in
    // ------------------------------------------------------------------
    task automatic run_session(input int n_items, input int step_hi);
        logic [31:0] now_ms;
        logic [1:0]  func;
        bit          lack, full, key;
        int          r;
        now_ms = {16'd0, startup_at} - $urandom_range(0, 3 * step_hi);
        lack   = 1'b0;
        full   = 1'b0;
        send_cmd(FUNC_POWER_ON, now_ms, 1'b0, 1'b0, 1'b0);
        for (int i = 1; i < n_items; i++) begin
            r = $urandom_range(0, 999);
            if (r < 40) begin
                // noise: any command, any time, any levels
                send_cmd(2'($urandom_range(0, 3)), $urandom(), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                continue;
            end
            if (r < 45) drain_results();
            if ((seq_run == RUN_CODE_DOWN || seq_run == RUN_CODE_POWERED)
                    && $urandom_range(0, 4) == 0)
                func = FUNC_POWER_ON;
            else if (r < 55) func = FUNC_SHUTDOWN;
            else if (r < 62) func = FUNC_UNUSED;
            else func = FUNC_CHECK;
            r = $urandom_range(0, 99);
            if (r < 75) now_ms += $urandom_range(0, step_hi);
            else if (r < 98) now_ms += $urandom_range(step_hi, 20 * step_hi);
            else now_ms += $urandom();
            if (lack ? ($urandom_range(0, 99) < 20) : ($urandom_range(0, 99) < 3))
                lack = !lack;
            if ($urandom_range(0, 99) < 7) full = !full;
            key = ($urandom_range(0, 99) < 2);
            send_cmd(func, now_ms, lack, full, key);
        end
    endtask

    task automatic run_phase(input int total, input int step_hi);
        int n, done_here;
        done_here = 0;
        while (done_here < total) begin
            n = $urandom_range(20, 120);
            if (n > total - done_here) n = total - done_here;
            run_session(n, step_hi);
            done_here += n;
        end
    endtask

    // ------------------------------------------------------------------
    // directed tests, reset timer values
    // ------------------------------------------------------------------
    task automatic test_idle_and_startup();
        // switches and key are ignored before running; unused command changes nothing
        send_cmd(FUNC_CHECK, 32'd0, 1, 1, 1);
        send_cmd(FUNC_UNUSED, 32'hFFFF_FFFF, 1, 1, 1);
        send_cmd(FUNC_POWER_ON, 32'd0, 0, 0, 0);
        // one below and exactly at the startup delay
        send_cmd(FUNC_CHECK, 32'd1999, 1, 1, 1);
        send_cmd(FUNC_CHECK, 32'd2000, 0, 0, 0);
    endtask

    task automatic test_wash_fill_cycle();
        send_cmd(FUNC_CHECK, 32'd2000, 0, 0, 0);   // idle -> wash
        send_cmd(FUNC_CHECK, 32'd2001, 0, 0, 0);   // wash timer starts
        send_cmd(FUNC_CHECK, 32'd20000, 0, 0, 0);  // one short of the long wash
        send_cmd(FUNC_CHECK, 32'd20001, 0, 0, 0);  // wash ends -> fill
        send_cmd(FUNC_CHECK, 32'd20002, 0, 0, 0);  // fill timer starts
        send_cmd(FUNC_CHECK, 32'd20003, 0, 0, 0);  // pump on, single beep
        send_cmd(FUNC_CHECK, 32'd20004, 0, 1, 0);  // tank full
        send_cmd(FUNC_CHECK, 32'd20005, 0, 1, 0);  // full alarm beep
        send_cmd(FUNC_CHECK, 32'd20006, 0, 0, 0);  // back to fill
        send_cmd(FUNC_CHECK, 32'd20007, 0, 0, 0);
    endtask

    task automatic test_rinse_and_overrides();
        // rinse due on the same check that raises the fill alarm: start then cancel
        send_cmd(FUNC_CHECK, 32'd3620001, 0, 0, 0);
        send_cmd(FUNC_CHECK, 32'd3620002, 0, 0, 0);
        send_cmd(FUNC_CHECK, 32'd3620003, 0, 0, 1);   // key turns the rinse into a long wash
        send_cmd(FUNC_CHECK, 32'd3620004, 1, 0, 0);   // lack overrides wash
        send_cmd(FUNC_CHECK, 32'd3620005, 1, 0, 1);   // key wins over a held lack
        send_cmd(FUNC_CHECK, 32'd3620006, 0, 0, 0);
        send_cmd(FUNC_CHECK, 32'd3638006, 0, 0, 0);
    endtask

    task automatic test_fault_and_restart();
        send_cmd(FUNC_CHECK, 32'd3638007, 0, 0, 0);
        send_cmd(FUNC_CHECK, 32'd7220007, 0, 0, 0);   // overlong fill -> fault
        send_cmd(FUNC_CHECK, 32'd7220008, 0, 0, 0);   // fault alarm
        send_cmd(FUNC_POWER_ON, 32'd7220009, 0, 0, 0);
        send_cmd(FUNC_CHECK, 32'hFFFF_FFFF, 0, 0, 0);
        send_cmd(FUNC_CHECK, 32'hFFFF_FFFF, 1, 0, 0); // idle with lack -> lack
        send_cmd(FUNC_CHECK, 32'hFFFF_FFFF, 1, 0, 0);
        send_cmd(FUNC_SHUTDOWN, 32'd0, 1, 1, 1);
        send_cmd(FUNC_CHECK, 32'd0, 0, 0, 0);          // no second fault alarm
    endtask

    // ------------------------------------------------------------------
    // random tests, one timer setting each
    // ------------------------------------------------------------------
    task automatic test_short_timers();
        load_timers(32'd30, 32'd10, 32'd200, 32'd400, 16'd50, 1'b0);
        run_phase(550, 12);
    endtask

    task automatic test_zero_timers();
        load_timers(32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 1'b0);
        run_phase(250, 3);
    endtask

    // deadlines wrap around, so most compares pass at once
    task automatic test_max_timers();
        load_timers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    16'hFFFF, 1'b0);
        run_phase(250, 40);
    endtask

    // no idling on either side
    task automatic test_back_to_back();
        load_timers($urandom_range(0, 60), $urandom_range(0, 30), $urandom_range(0, 400),
                    $urandom_range(0, 800), 16'($urandom_range(0, 100)), 1'b0);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        run_phase(350, 15);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    task automatic test_random_timers();
        load_timers($urandom_range(0, 5000), $urandom_range(0, 3000),
                    $urandom_range(0, 30000), $urandom_range(0, 60000),
                    16'($urandom_range(0, 16'hFFFF)), 1'b1);
        run_phase(300, 500);
    endtask

    task automatic test_slow_timers();
        load_timers(32'd18000, 32'd10000, 32'd3600000, 32'd7200000, 16'd2000, 1'b0);
        run_phase(250, 20000);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int waited;
        init_model();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_idle_and_startup();
        test_wash_fill_cycle();
        test_rinse_and_overrides();
        test_fault_and_restart();
        test_short_timers();
        test_zero_timers();
        test_max_timers();
        test_back_to_back();
        test_random_timers();
        test_slow_timers();

        // let the last results come out, then check that none is left outstanding
        s_tvalid <= 1'b0;
        waited = 0;
        while (expected_outputs.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (8) @(posedge aclk);
        if (expected_outputs.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived, expected %0d actual 0", $time,
                     expected_outputs.size(), expected_outputs.size());
        end

        $display("ran %0d commands and took %0d results over directed cases and six timer setups",
                 commands_sent, results_taken);
        $display("task idle/wash/fill/lack/full %0d/%0d/%0d/%0d/%0d, beeps one/ten/long %0d/%0d/%0d",
                 task_hits[0], task_hits[1], task_hits[2], task_hits[3], task_hits[4],
                 beep_hits[1], beep_hits[2], beep_hits[3]);
        if (errors == 0) begin
            $display("tb_purifier_wash_fill_sequencer passed");
        end else begin
            $display("tb_purifier_wash_fill_sequencer failed");
        end
        $finish;
    end

    // hard stop in case a handshake hangs
    initial begin
        #8_000_000;
        $display("tb_purifier_wash_fill_sequencer failed");
        $finish;
    end

endmodule
